// ===== design/satd_pkg.sv =====
package satd_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_SIZE_SELECT       = 8'd0;
  localparam logic [7:0] CFG_NAME_GAP          = 8'd1;
  localparam logic [7:0] CFG_TILE_BASE_SEGMENT = 8'd2;
  localparam logic [7:0] CFG_INTERLACE_MODE    = 8'd3;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 8;

  // Viewport limits
  localparam logic [7:0] VIEW_HEIGHT = 8'd224;
  localparam logic [8:0] LINE_WRAP   = 9'd256;

  // Size selects at or above this take the interlace height override
  localparam logic [2:0] INTERLACE_SEL_MIN = 3'd6;
  localparam logic [6:0] INTERLACE_HEIGHT  = 7'd16;

  // Sprite dimension tables, indexed by size_select
  localparam logic [6:0] SMALL_W [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd16, 7'd16};
  localparam logic [6:0] SMALL_H [8] = '{7'd8, 7'd8, 7'd8, 7'd16, 7'd16, 7'd32, 7'd32, 7'd32};
  localparam logic [6:0] LARGE_W [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd32, 7'd32};
  localparam logic [6:0] LARGE_H [8] = '{7'd16, 7'd32, 7'd64, 7'd32, 7'd64, 7'd64, 7'd64, 7'd32};

  typedef struct packed {
    logic [2:0] size_select;
    logic [1:0] name_gap;
    logic [2:0] tile_base_segment;
    logic       interlace_mode;
  } satd_cfg_t;

  typedef struct packed {
    logic [7:0] x_low;
    logic       x_high;
    logic       large_select;
    logic [7:0] y_pos;
    logic [7:0] char_number;
    logic [7:0] attr_byte;
    logic [5:0] pixel_col;
    logic [5:0] pixel_row;
  } satd_item_t;

  typedef struct packed {
    logic signed [8:0] sprite_x;
    logic [6:0]        sprite_width;
    logic [6:0]        sprite_height;
    logic [2:0]        palette_number;
    logic [1:0]        priority_level;
    logic              flip_horizontal;
    logic              flip_vertical;
    logic              on_screen;
    logic [7:0]        tile_number;
    logic [14:0]       tile_word_address;
  } satd_result_t;

endpackage

// ===== design/satd_cfg.sv =====
module satd_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [satd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [satd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output satd_pkg::satd_cfg_t                 cfg_o
);

  satd_pkg::satd_cfg_t cfg_r;
  satd_pkg::satd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        satd_pkg::CFG_SIZE_SELECT:       cfg_nxt.size_select       = cfg_data[2:0];
        satd_pkg::CFG_NAME_GAP:          cfg_nxt.name_gap          = cfg_data[1:0];
        satd_pkg::CFG_TILE_BASE_SEGMENT: cfg_nxt.tile_base_segment = cfg_data[2:0];
        satd_pkg::CFG_INTERLACE_MODE:    cfg_nxt.interlace_mode    = cfg_data[0];
        default: cfg_nxt = cfg_r; // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== design/satd_map.sv =====
module satd_map (
  input  satd_pkg::satd_cfg_t    cfg_i,
  input  satd_pkg::satd_item_t   item_i,
  output satd_pkg::satd_result_t res_o
);

  logic [6:0]        w;
  logic [6:0]        h;
  logic [7:0]        w8;
  logic [7:0]        col8;
  logic [7:0]        row8;
  logic [7:0]        src_x;
  logic [7:0]        src_y;
  logic              hflip;
  logic              vflip;
  logic signed [9:0] x_end;
  logic [8:0]        y_end;
  logic              horiz;
  logic              vert;
  logic [3:0]        tile_row;
  logic [3:0]        tile_col;
  logic [2:0]        name_step;
  logic [14:0]       base;
  logic [14:0]       name_off;

  always_comb begin
    w = item_i.large_select ? satd_pkg::LARGE_W[cfg_i.size_select]
                            : satd_pkg::SMALL_W[cfg_i.size_select];
    h = item_i.large_select ? satd_pkg::LARGE_H[cfg_i.size_select]
                            : satd_pkg::SMALL_H[cfg_i.size_select];
    if (!item_i.large_select && cfg_i.interlace_mode &&
        (cfg_i.size_select >= satd_pkg::INTERLACE_SEL_MIN)) begin
      h = satd_pkg::INTERLACE_HEIGHT;
    end

    hflip = item_i.attr_byte[6];
    vflip = item_i.attr_byte[7];
    w8    = {1'b0, w};
    col8  = {2'b00, item_i.pixel_col};
    row8  = {2'b00, item_i.pixel_row};

    src_x = hflip ? (w8 - 8'd1 - col8) : col8;

    // Tall sprites mirror each square half separately
    if (!vflip) begin
      src_y = row8;
    end else if (w == h) begin
      src_y = {1'b0, h} - 8'd1 - row8;
    end else if (row8 < w8) begin
      src_y = w8 - 8'd1 - row8;
    end else begin
      src_y = w8 + w8 + w8 - 8'd1 - row8;
    end

    // Screen X is always below 256, so only the right edge matters
    x_end = $signed({item_i.x_high, item_i.x_high, item_i.x_low}) + $signed({3'b000, w});
    horiz = (x_end > 10'sd0);
    y_end = {1'b0, item_i.y_pos} + {2'b00, h};
    vert  = (item_i.y_pos < satd_pkg::VIEW_HEIGHT) || (y_end > satd_pkg::LINE_WRAP);

    tile_row = item_i.char_number[7:4] + src_y[6:3];
    tile_col = item_i.char_number[3:0] + src_x[6:3];

    name_step = {1'b0, cfg_i.name_gap} + 3'd1;
    base      = {cfg_i.tile_base_segment[1:0], 13'd0};
    name_off  = item_i.attr_byte[0] ? {name_step, 12'd0} : 15'd0;

    res_o.sprite_x          = $signed({item_i.x_high, item_i.x_low});
    res_o.sprite_width      = w;
    res_o.sprite_height     = h;
    res_o.palette_number    = item_i.attr_byte[3:1];
    res_o.priority_level    = item_i.attr_byte[5:4];
    res_o.flip_horizontal   = hflip;
    res_o.flip_vertical     = vflip;
    res_o.on_screen         = horiz && vert;
    res_o.tile_number       = {tile_row, tile_col};
    res_o.tile_word_address = base + name_off + {3'b000, tile_row, tile_col, 4'd0};
  end

endmodule

// ===== design/sprite_attribute_decode_and_tile_address.sv =====
// Each transaction taken passes the input register, the decode and the result register;
// its result is then on the out_ ports for exactly one cycle with out_strobe high.
// Throughput: one transaction per cycle; busy is always low, set by the input and
// result registers around a combinational decode. The receiver cannot stall.
// Reset (rst_n low, synchronous): clears all configuration registers to zero and
// drops any transaction in flight.
module sprite_attribute_decode_and_tile_address (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       in_x_low,
  input  logic                             in_x_high,
  input  logic                             in_large_select,
  input  logic [7:0]                       in_y_pos,
  input  logic [7:0]                       in_char_number,
  input  logic [7:0]                       in_attr_byte,
  input  logic [5:0]                       in_pixel_col,
  input  logic [5:0]                       in_pixel_row,
  // result channel
  output logic                             out_strobe,
  output logic signed [8:0]                out_sprite_x,
  output logic [6:0]                       out_sprite_width,
  output logic [6:0]                       out_sprite_height,
  output logic [2:0]                       out_palette_number,
  output logic [1:0]                       out_priority_level,
  output logic                             out_flip_horizontal,
  output logic                             out_flip_vertical,
  output logic                             out_on_screen,
  output logic [7:0]                       out_tile_number,
  output logic [14:0]                      out_tile_word_address,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [satd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [satd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  satd_pkg::satd_cfg_t    cfg;
  satd_pkg::satd_item_t   item_r;
  satd_pkg::satd_item_t   item_nxt;
  logic                   item_valid_r;
  satd_pkg::satd_result_t res;
  satd_pkg::satd_result_t res_r;
  logic                   res_valid_r;

  // No stall source anywhere: take a transaction every cycle, and take
  // configuration writes at once.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  satd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  always_comb begin
    item_nxt.x_low        = in_x_low;
    item_nxt.x_high       = in_x_high;
    item_nxt.large_select = in_large_select;
    item_nxt.y_pos        = in_y_pos;
    item_nxt.char_number  = in_char_number;
    item_nxt.attr_byte    = in_attr_byte;
    item_nxt.pixel_col    = in_pixel_col;
    item_nxt.pixel_row    = in_pixel_row;
  end

  // Input stage: capture the transaction; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= item_nxt;
    end
  end

  // Decode the sprite and map the pixel in one pass
  satd_map u_map (
    .cfg_i  (cfg),
    .item_i (item_r),
    .res_o  (res)
  );

  // Result stage: present each result for one cycle only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r) begin
      res_r <= res;
    end
  end

  assign out_strobe            = res_valid_r;
  assign out_sprite_x          = res_r.sprite_x;
  assign out_sprite_width      = res_r.sprite_width;
  assign out_sprite_height     = res_r.sprite_height;
  assign out_palette_number    = res_r.palette_number;
  assign out_priority_level    = res_r.priority_level;
  assign out_flip_horizontal   = res_r.flip_horizontal;
  assign out_flip_vertical     = res_r.flip_vertical;
  assign out_on_screen         = res_r.on_screen;
  assign out_tile_number       = res_r.tile_number;
  assign out_tile_word_address = res_r.tile_word_address;

  // Every accepted transaction yields exactly one result, through the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##2 !out_strobe)
    else $error("result produced without a transaction");

  // Sprite dimensions are always a power of two from 8 to 64
  a_size_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($onehot(out_sprite_width) && (out_sprite_width[2:0] == 3'b000) &&
                    $onehot(out_sprite_height) && (out_sprite_height[2:0] == 3'b000)))
    else $error("sprite size outside the size tables");

  // Tiles are 16 words each, so the address is tile aligned and its bits 11:4 hold the tile number
  a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_tile_word_address[3:0] == 4'd0) &&
                    (out_tile_word_address[11:4] == out_tile_number)))
    else $error("tile address does not match tile number");

endmodule

// ===== tb/sprite_decode_checker.sv =====
`timescale 1ns / 1ps

module sprite_decode_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  satd_pkg::satd_item_t             cmd,
  input  logic                             out_strobe,
  input  satd_pkg::satd_result_t           result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [satd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [satd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                      mismatches,
  output int unsigned                      outstanding
);

  // Sprite dimensions in pixels, indexed by size select
  localparam int unsigned NARROW_W [8] = '{8, 8, 8, 16, 16, 32, 16, 16};
  localparam int unsigned NARROW_H [8] = '{8, 8, 8, 16, 16, 32, 32, 32};
  localparam int unsigned WIDE_W   [8] = '{16, 32, 64, 32, 64, 64, 32, 32};
  localparam int unsigned WIDE_H   [8] = '{16, 32, 64, 32, 64, 64, 64, 32};

  satd_pkg::satd_cfg_t    shadow_regs;
  satd_pkg::satd_result_t expected_sprites[$];
  satd_pkg::satd_result_t want;
  int unsigned            result_idx;

  function automatic satd_pkg::satd_result_t predict_sprite(input satd_pkg::satd_item_t it,
                                                            input satd_pkg::satd_cfg_t c);
    int unsigned            w;
    int unsigned            h;
    int unsigned            raw_x;
    int                     sx;
    logic [31:0]            tmp;
    logic [7:0]             src_x;
    logic [7:0]             src_y;
    logic [3:0]             tile_row;
    logic [3:0]             tile_col;
    logic [31:0]            base;
    bit                     horiz;
    bit                     vert;
    satd_pkg::satd_result_t r;
    w = it.large_select ? WIDE_W[c.size_select] : NARROW_W[c.size_select];
    h = it.large_select ? WIDE_H[c.size_select] : NARROW_H[c.size_select];
    if (!it.large_select && c.interlace_mode && c.size_select >= 3'd6) begin
      h = 16;
    end
    raw_x = {23'd0, it.x_high, it.x_low};
    sx = int'(raw_x) - ((raw_x >= 256) ? 512 : 0);
    horiz = (sx < 256) && (sx + int'(w) > 0);
    vert = (it.y_pos < 224) || (it.y_pos + h > 256);

    if (it.attr_byte[6]) begin
      tmp = w - 1 - it.pixel_col;
      src_x = tmp[7:0];
    end else begin
      src_x = {2'b00, it.pixel_col};
    end

    // tall sprites flip each square half on its own
    if (!it.attr_byte[7]) begin
      tmp = {26'd0, it.pixel_row};
    end else if (w == h) begin
      tmp = h - 1 - it.pixel_row;
    end else if (it.pixel_row < w) begin
      tmp = w - 1 - it.pixel_row;
    end else begin
      tmp = 3 * w - 1 - it.pixel_row;
    end
    src_y = tmp[7:0];

    tile_row = it.char_number[7:4] + src_y[6:3];
    tile_col = it.char_number[3:0] + src_x[6:3];

    base = {29'd0, c.tile_base_segment};
    base = base << 13;
    if (it.attr_byte[0]) begin
      base = base + (({30'd0, c.name_gap} + 32'd1) << 12);
    end

    r.sprite_x          = raw_x[8:0];
    r.sprite_width      = w[6:0];
    r.sprite_height     = h[6:0];
    r.palette_number    = it.attr_byte[3:1];
    r.priority_level    = it.attr_byte[5:4];
    r.flip_horizontal   = it.attr_byte[6];
    r.flip_vertical     = it.attr_byte[7];
    r.on_screen         = horiz && vert;
    r.tile_number       = {tile_row, tile_col};
    tmp = base + {20'd0, tile_row, tile_col, 4'd0};
    r.tile_word_address = tmp[14:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int wanted);
    $display("%0t: result %0d %s: got %0d, expected %0d", $realtime, result_idx, what, got,
             wanted);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input int got, input int wanted);
    if (got != wanted) begin
      report_mismatch(what, got, wanted);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_regs = '0;
      expected_sprites.delete();
    end else begin
      if (out_strobe) begin
        if (expected_sprites.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_sprites.pop_front();
          compare_field("sprite_x", int'(result.sprite_x), int'(want.sprite_x));
          compare_field("sprite_width", result.sprite_width, want.sprite_width);
          compare_field("sprite_height", result.sprite_height, want.sprite_height);
          compare_field("palette_number", result.palette_number, want.palette_number);
          compare_field("priority_level", result.priority_level, want.priority_level);
          compare_field("flip_horizontal", result.flip_horizontal, want.flip_horizontal);
          compare_field("flip_vertical", result.flip_vertical, want.flip_vertical);
          compare_field("on_screen", result.on_screen, want.on_screen);
          compare_field("tile_number", result.tile_number, want.tile_number);
          compare_field("tile_word_address", result.tile_word_address,
                        want.tile_word_address);
        end
        result_idx++;
      end
      if (start && !busy) begin
        expected_sprites = {expected_sprites, predict_sprite(cmd, shadow_regs)};
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          satd_pkg::CFG_SIZE_SELECT:       shadow_regs.size_select       = cfg_data[2:0];
          satd_pkg::CFG_NAME_GAP:          shadow_regs.name_gap          = cfg_data[1:0];
          satd_pkg::CFG_TILE_BASE_SEGMENT: shadow_regs.tile_base_segment = cfg_data[2:0];
          satd_pkg::CFG_INTERLACE_MODE:    shadow_regs.interlace_mode    = cfg_data[0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_sprites.size();
  end

endmodule

// ===== tb/tb_sprite_attribute_decode_and_tile_address.sv =====
`timescale 1ns / 1ps

module tb_sprite_attribute_decode_and_tile_address;

  // Cycles to let pass once the last result is in (pipeline is two deep)
  localparam int SETTLE_CYCLES = 4;
  // Cycles without any handshake before the run is declared hung
  localparam int QUIET_LIMIT = 1000;
  // An index outside the register map: writes to it must change nothing
  localparam logic [satd_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_INDEX = 8'hA5;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 48;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  satd_pkg::satd_item_t             cmd = '0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [satd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [satd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  logic                             out_strobe;
  logic signed [8:0]                out_sprite_x;
  logic [6:0]                       out_sprite_width;
  logic [6:0]                       out_sprite_height;
  logic [2:0]                       out_palette_number;
  logic [1:0]                       out_priority_level;
  logic                             out_flip_horizontal;
  logic                             out_flip_vertical;
  logic                             out_on_screen;
  logic [7:0]                       out_tile_number;
  logic [14:0]                      out_tile_word_address;
  satd_pkg::satd_result_t           result_bus;

  int unsigned                      mismatches;
  int unsigned                      outstanding;
  int unsigned                      quiet_cycles = 0;
  // Chance in percent that a burst of idle cycles comes before a transaction
  int unsigned                      idle_pct = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  sprite_attribute_decode_and_tile_address uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_x_low             (cmd.x_low),
    .in_x_high            (cmd.x_high),
    .in_large_select      (cmd.large_select),
    .in_y_pos             (cmd.y_pos),
    .in_char_number       (cmd.char_number),
    .in_attr_byte         (cmd.attr_byte),
    .in_pixel_col         (cmd.pixel_col),
    .in_pixel_row         (cmd.pixel_row),
    .out_strobe           (out_strobe),
    .out_sprite_x         (out_sprite_x),
    .out_sprite_width     (out_sprite_width),
    .out_sprite_height    (out_sprite_height),
    .out_palette_number   (out_palette_number),
    .out_priority_level   (out_priority_level),
    .out_flip_horizontal  (out_flip_horizontal),
    .out_flip_vertical    (out_flip_vertical),
    .out_on_screen        (out_on_screen),
    .out_tile_number      (out_tile_number),
    .out_tile_word_address(out_tile_word_address),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Gather the result ports in the order of the package's result struct
  assign result_bus = {out_sprite_x, out_sprite_width, out_sprite_height, out_palette_number,
                       out_priority_level, out_flip_horizontal, out_flip_vertical,
                       out_on_screen, out_tile_number, out_tile_word_address};

  sprite_decode_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe),
    .result     (result_bus),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic satd_pkg::satd_item_t pack_sprite(input logic [7:0] xl, input logic xh,
                                                       input logic lg, input logic [7:0] y,
                                                       input logic [7:0] chr,
                                                       input logic [7:0] attr,
                                                       input logic [5:0] col,
                                                       input logic [5:0] row);
    satd_pkg::satd_item_t it;
    it.x_low        = xl;
    it.x_high       = xh;
    it.large_select = lg;
    it.y_pos        = y;
    it.char_number  = chr;
    it.attr_byte    = attr;
    it.pixel_col    = col;
    it.pixel_row    = row;
    return it;
  endfunction

  // Random sprite; half of the pixels are drawn from the usual sprite sizes and
  // a quarter of the rows sit around the bottom of the viewport
  function automatic satd_pkg::satd_item_t random_sprite();
    satd_pkg::satd_item_t it;
    logic [63:0]          rnd;
    rnd = {$urandom, $urandom};
    it = rnd[$bits(satd_pkg::satd_item_t)-1:0];
    if ($urandom_range(0, 1)) begin
      it.pixel_col = 6'($urandom_range(0, 31));
      it.pixel_row = 6'($urandom_range(0, 31));
    end
    if ($urandom_range(0, 3) == 0) begin
      it.y_pos = 8'($urandom_range(190, 255));
    end
    return it;
  endfunction

  // Present one transaction and hold it until it is taken; start stays high
  // afterwards so that back-to-back transactions need no dead cycle
  task automatic send_sprite(input satd_pkg::satd_item_t it);
    if ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= it;
    do @(posedge clk); while (busy);
  endtask

  // Drop start, then wait until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leave valid high on return; the caller drops it after the last write
  task automatic write_reg(input logic [satd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [satd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write the whole register set while the block is idle; unused data bits
  // carry noise, and one stray write goes to an unmapped index
  task automatic load_regs(input satd_pkg::satd_cfg_t c);
    logic [7:0] noise;
    drain();
    noise = 8'($urandom);
    write_reg(satd_pkg::CFG_SIZE_SELECT, {noise[7:3], c.size_select});
    noise = 8'($urandom);
    write_reg(satd_pkg::CFG_NAME_GAP, {noise[7:2], c.name_gap});
    noise = 8'($urandom);
    write_reg(satd_pkg::CFG_TILE_BASE_SEGMENT, {noise[7:3], c.tile_base_segment});
    noise = 8'($urandom);
    write_reg(satd_pkg::CFG_INTERLACE_MODE, {noise[7:1], c.interlace_mode});
    write_reg(CFG_UNMAPPED_INDEX, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    satd_pkg::satd_cfg_t regs;
    logic [31:0]         rnd;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tall sprites (16x32 small, 32x64 large), top segment plus the widest
    // name gap so the second name table runs past 15 address bits
    idle_pct = 30;
    load_regs('{3'd6, 2'd3, 3'd7, 1'b0});
    send_sprite(pack_sprite(8'd0, 1'b0, 1'b0, 8'd0, 8'h00, 8'h00, 6'd0, 6'd0));
    send_sprite(pack_sprite(8'd255, 1'b1, 1'b1, 8'd255, 8'hFF, 8'hFF, 6'd63, 6'd63));
    // Leftmost X, fully off the left edge
    send_sprite(pack_sprite(8'h00, 1'b1, 1'b0, 8'd100, 8'h12, 8'h00, 6'd0, 6'd0));
    // Partly on the left edge, then just touching it from outside
    send_sprite(pack_sprite(8'hF8, 1'b1, 1'b0, 8'd100, 8'h12, 8'h0E, 6'd3, 6'd3));
    send_sprite(pack_sprite(8'hF0, 1'b1, 1'b0, 8'd100, 8'h12, 8'h30, 6'd5, 6'd5));
    // Vertical viewport limits, with and without wrap past line 256
    send_sprite(pack_sprite(8'd255, 1'b0, 1'b1, 8'd223, 8'h00, 8'h3E, 6'd0, 6'd0));
    send_sprite(pack_sprite(8'd10, 1'b0, 1'b0, 8'd224, 8'h00, 8'h00, 6'd0, 6'd0));
    send_sprite(pack_sprite(8'd10, 1'b0, 1'b0, 8'd225, 8'h00, 8'h00, 6'd0, 6'd0));
    // Tall sprite flipped vertically: upper half, lower half, beyond the size
    send_sprite(pack_sprite(8'd40, 1'b0, 1'b0, 8'd50, 8'h21, 8'h80, 6'd0, 6'd3));
    send_sprite(pack_sprite(8'd40, 1'b0, 1'b0, 8'd50, 8'h21, 8'h80, 6'd0, 6'd20));
    send_sprite(pack_sprite(8'd40, 1'b0, 1'b0, 8'd50, 8'h21, 8'h80, 6'd0, 6'd63));
    // Horizontal flip past the width, then no flip with tile nibbles wrapping
    send_sprite(pack_sprite(8'd40, 1'b0, 1'b0, 8'd50, 8'h21, 8'h40, 6'd40, 6'd7));
    send_sprite(pack_sprite(8'd40, 1'b0, 1'b0, 8'd50, 8'hFF, 8'h00, 6'd63, 6'd63));
    // Large tall sprite on the second name table, with both flips and with none
    send_sprite(pack_sprite(8'd40, 1'b0, 1'b1, 8'd50, 8'hEE, 8'hC1, 6'd9, 6'd40));
    send_sprite(pack_sprite(8'd40, 1'b0, 1'b1, 8'd50, 8'h0F, 8'h01, 6'd31, 6'd63));

    // Interlace turns the small 16x32 into a square 16x16
    load_regs('{3'd7, 2'd1, 3'd2, 1'b1});
    send_sprite(pack_sprite(8'd0, 1'b0, 1'b0, 8'd0, 8'h10, 8'h80, 6'd0, 6'd5));
    send_sprite(pack_sprite(8'd128, 1'b0, 1'b0, 8'd210, 8'h10, 8'hC0, 6'd15, 6'd15));
    send_sprite(pack_sprite(8'd128, 1'b0, 1'b1, 8'd210, 8'h10, 8'h80, 6'd0, 6'd31));

    // Smallest and largest square sprites
    load_regs('{3'd2, 2'd0, 3'd0, 1'b0});
    send_sprite(pack_sprite(8'd200, 1'b0, 1'b1, 8'd200, 8'h77, 8'hC0, 6'd0, 6'd0));
    send_sprite(pack_sprite(8'd192, 1'b0, 1'b1, 8'd192, 8'h88, 8'h40, 6'd63, 6'd63));
    send_sprite(pack_sprite(8'd7, 1'b0, 1'b0, 8'd249, 8'h99, 8'h81, 6'd7, 6'd7));

    // Random phases: register extremes first, then random settings; some
    // phases run back to back, and the last one never idles
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       regs = '{3'd0, 2'd0, 3'd0, 1'b0};
        1:       regs = '{3'd7, 2'd3, 3'd7, 1'b1};
        2:       regs = '{3'd6, 2'd2, 3'd5, 1'b1};
        default: begin
          rnd  = $urandom;
          regs = rnd[$bits(satd_pkg::satd_cfg_t)-1:0];
        end
      endcase
      load_regs(regs);
      idle_pct = (p == RANDOM_PHASES - 1 || p % 3 == 1) ? 0 : $urandom_range(15, 50);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_sprite(random_sprite());
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/satd_pkg.sv
design/satd_cfg.sv
design/satd_map.sv
design/sprite_attribute_decode_and_tile_address.sv
tb/sprite_decode_checker.sv
tb/tb_sprite_attribute_decode_and_tile_address.sv
